### rtl/core/dnsarp_pkg.sv
package dnsarp_pkg;

  localparam int unsigned HeaderBytes = 12;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] address;
  } out_word_t;

  typedef enum logic [3:0] {
    PH_HEADER = 4'd0,
    PH_QNAME  = 4'd1,
    PH_QLABEL = 4'd2,
    PH_QPTR   = 4'd3,
    PH_QTAIL  = 4'd4,
    PH_ANAME  = 4'd5,
    PH_ALABEL = 4'd6,
    PH_APTR   = 4'd7,
    PH_AFIXED = 4'd8,
    PH_ADATA  = 4'd9,
    PH_RSKIP  = 4'd10,
    PH_DONE   = 4'd11,
    PH_FOUND  = 4'd12
  } phase_t;

  localparam logic [2:0] ST_FOUND        = 3'd0;
  localparam logic [2:0] ST_TOO_SHORT    = 3'd1;
  localparam logic [2:0] ST_ID_MISMATCH  = 3'd2;
  localparam logic [2:0] ST_NOT_RESPONSE = 3'd3;
  localparam logic [2:0] ST_SERVER_ERROR = 3'd4;
  localparam logic [2:0] ST_NO_ANSWERS   = 3'd5;
  localparam logic [2:0] ST_NO_A_RECORD  = 3'd6;
  localparam logic [2:0] ST_NONE         = 3'd0;

  localparam logic [7:0]  PtrMark   = 8'hC0;
  localparam logic [15:0] TypeA     = 16'd1;
  localparam logic [15:0] ALength   = 16'd4;
  localparam logic [15:0] FixedLen  = 16'd10;
  localparam logic [15:0] TailLen   = 16'd4;

endpackage

### rtl/core/dns_a_record_response_parser_unit.sv
// DNS response parser: takes one packet byte per word, one word per cycle with no
// gaps needed, and on the word marked last delivers one result word (status and the
// first IPv4 A address) from a register. Bytes past MAX_PACKET are
// dropped but their last mark still closes the packet. Results sit in a two-entry
// output buffer, so input keeps flowing while a result waits; input stalls only when
// both entries are full. expected_id may be written only between packets.
module dns_a_record_response_parser_unit #(
  parameter int unsigned MAX_PACKET = 512
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [15:0]           cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  dnsarp_pkg::in_word_t  in_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output dnsarp_pkg::out_word_t out_word
);

  localparam int unsigned PosW = $clog2(MAX_PACKET + 1);
  localparam logic [PosW-1:0] PosMax   = PosW'(MAX_PACKET);
  localparam logic [PosW-1:0] PosIdEnd = PosW'(1);
  localparam logic [PosW-1:0] PosFlags = PosW'(3);
  localparam logic [PosW-1:0] PosAnCnt = PosW'(7);
  localparam logic [PosW-1:0] PosHdEnd = PosW'(dnsarp_pkg::HeaderBytes - 1);
  localparam logic [PosW-1:0] PosHdLen = PosW'(dnsarp_pkg::HeaderBytes);

  logic [15:0]        expected_id;
  logic [PosW-1:0]    byte_position;
  dnsarp_pkg::phase_t parse_phase;
  logic [15:0]        skip_remaining;
  logic [15:0]        answers_left;
  logic [15:0]        header_word;
  logic [15:0]        record_type;
  logic [15:0]        record_length;
  logic [31:0]        address_accum;
  logic [2:0]         verdict;

  logic [PosW-1:0]    byte_position_next;
  dnsarp_pkg::phase_t parse_phase_next;
  logic [15:0]        skip_remaining_next;
  logic [15:0]        answers_left_next;
  logic [15:0]        header_word_next;
  logic [15:0]        record_type_next;
  logic [15:0]        record_length_next;
  logic [31:0]        address_accum_next;
  logic [2:0]         verdict_next;

  logic                  skid_valid;
  dnsarp_pkg::out_word_t skid_word;
  dnsarp_pkg::out_word_t result;

  logic        in_acc;
  logic        take;
  logic        emit;
  logic        out_take;
  logic [7:0]  b;
  logic [15:0] hw_shift;
  logic [15:0] skip_dec;
  logic [15:0] ans_dec;
  logic [3:0]  afx_idx;
  logic [15:0] rt_new;
  logic [15:0] rl_new;

  assign in_ready = !skid_valid;
  assign in_acc   = in_valid && in_ready;
  assign take     = in_acc && (byte_position < PosMax);
  assign emit     = in_acc && in_word.last;
  assign out_take = out_valid && out_ready;
  assign b        = in_word.data_byte;
  assign hw_shift = {header_word[7:0], b};
  assign skip_dec = skip_remaining - 16'd1;
  assign ans_dec  = answers_left - 16'd1;
  assign afx_idx  = 4'd10 - skip_remaining[3:0];
  assign rt_new   = (afx_idx < 4'd2) ? {record_type[7:0], b} : record_type;
  assign rl_new   = (afx_idx >= 4'd8) ? {record_length[7:0], b} : record_length;

  // next state of the parser for one byte
  always_comb begin
    byte_position_next  = byte_position;
    parse_phase_next    = parse_phase;
    skip_remaining_next = skip_remaining;
    answers_left_next   = answers_left;
    header_word_next    = header_word;
    record_type_next    = record_type;
    record_length_next  = record_length;
    address_accum_next  = address_accum;
    verdict_next        = verdict;
    if (take) begin
      byte_position_next = byte_position + PosW'(1);
      unique case (parse_phase) inside
        dnsarp_pkg::PH_HEADER: begin
          header_word_next = hw_shift;
          if (byte_position == PosIdEnd && hw_shift != expected_id) begin
            verdict_next     = dnsarp_pkg::ST_ID_MISMATCH;
            parse_phase_next = dnsarp_pkg::PH_DONE;
          end else if (byte_position == PosFlags) begin
            if (!hw_shift[15]) begin
              verdict_next     = dnsarp_pkg::ST_NOT_RESPONSE;
              parse_phase_next = dnsarp_pkg::PH_DONE;
            end else if (hw_shift[3:0] != 4'd0) begin
              verdict_next     = dnsarp_pkg::ST_SERVER_ERROR;
              parse_phase_next = dnsarp_pkg::PH_DONE;
            end
          end else if (byte_position == PosAnCnt) begin
            answers_left_next = hw_shift;
            if (hw_shift == 16'd0) begin
              verdict_next     = dnsarp_pkg::ST_NO_ANSWERS;
              parse_phase_next = dnsarp_pkg::PH_DONE;
            end
          end else if (byte_position == PosHdEnd) begin
            parse_phase_next = dnsarp_pkg::PH_QNAME;
          end
        end
        dnsarp_pkg::PH_QNAME, dnsarp_pkg::PH_ANAME: begin
          if (b == 8'd0) begin
            if (parse_phase == dnsarp_pkg::PH_QNAME) begin
              skip_remaining_next = dnsarp_pkg::TailLen;
              parse_phase_next    = dnsarp_pkg::PH_QTAIL;
            end else begin
              skip_remaining_next = dnsarp_pkg::FixedLen;
              record_type_next    = 16'd0;
              record_length_next  = 16'd0;
              parse_phase_next    = dnsarp_pkg::PH_AFIXED;
            end
          end else if ((b & dnsarp_pkg::PtrMark) == dnsarp_pkg::PtrMark) begin
            parse_phase_next = (parse_phase == dnsarp_pkg::PH_QNAME) ?
                               dnsarp_pkg::PH_QPTR : dnsarp_pkg::PH_APTR;
          end else begin
            skip_remaining_next = {8'd0, b};
            parse_phase_next = (parse_phase == dnsarp_pkg::PH_QNAME) ?
                               dnsarp_pkg::PH_QLABEL : dnsarp_pkg::PH_ALABEL;
          end
        end
        dnsarp_pkg::PH_QLABEL, dnsarp_pkg::PH_ALABEL: begin
          skip_remaining_next = skip_dec;
          if (skip_dec == 16'd0) begin
            parse_phase_next = (parse_phase == dnsarp_pkg::PH_QLABEL) ?
                               dnsarp_pkg::PH_QNAME : dnsarp_pkg::PH_ANAME;
          end
        end
        dnsarp_pkg::PH_QPTR: begin
          skip_remaining_next = dnsarp_pkg::TailLen;
          parse_phase_next    = dnsarp_pkg::PH_QTAIL;
        end
        dnsarp_pkg::PH_APTR: begin
          skip_remaining_next = dnsarp_pkg::FixedLen;
          record_type_next    = 16'd0;
          record_length_next  = 16'd0;
          parse_phase_next    = dnsarp_pkg::PH_AFIXED;
        end
        dnsarp_pkg::PH_QTAIL: begin
          skip_remaining_next = skip_dec;
          if (skip_dec == 16'd0) begin
            if (answers_left == 16'd0) begin
              verdict_next     = dnsarp_pkg::ST_NO_A_RECORD;
              parse_phase_next = dnsarp_pkg::PH_DONE;
            end else begin
              parse_phase_next = dnsarp_pkg::PH_ANAME;
            end
          end
        end
        dnsarp_pkg::PH_AFIXED: begin
          record_type_next    = rt_new;
          record_length_next  = rl_new;
          skip_remaining_next = skip_dec;
          if (skip_dec == 16'd0) begin
            if (rt_new == dnsarp_pkg::TypeA && rl_new == dnsarp_pkg::ALength) begin
              skip_remaining_next = dnsarp_pkg::ALength;
              address_accum_next  = 32'd0;
              parse_phase_next    = dnsarp_pkg::PH_ADATA;
            end else if (rl_new == 16'd0) begin
              answers_left_next = ans_dec;
              if (ans_dec == 16'd0) begin
                verdict_next     = dnsarp_pkg::ST_NO_A_RECORD;
                parse_phase_next = dnsarp_pkg::PH_DONE;
              end else begin
                parse_phase_next = dnsarp_pkg::PH_ANAME;
              end
            end else begin
              skip_remaining_next = rl_new;
              parse_phase_next    = dnsarp_pkg::PH_RSKIP;
            end
          end
        end
        dnsarp_pkg::PH_ADATA: begin
          address_accum_next  = {address_accum[23:0], b};
          skip_remaining_next = skip_dec;
          if (skip_dec == 16'd0) begin
            parse_phase_next = dnsarp_pkg::PH_FOUND;
          end
        end
        dnsarp_pkg::PH_RSKIP: begin
          skip_remaining_next = skip_dec;
          if (skip_dec == 16'd0) begin
            answers_left_next = ans_dec;
            if (ans_dec == 16'd0) begin
              verdict_next     = dnsarp_pkg::ST_NO_A_RECORD;
              parse_phase_next = dnsarp_pkg::PH_DONE;
            end else begin
              parse_phase_next = dnsarp_pkg::PH_ANAME;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result for a packet that ends on this word
  always_comb begin
    result.address = 32'd0;
    if (byte_position_next < PosHdLen) begin
      result.status = dnsarp_pkg::ST_TOO_SHORT;
    end else if (parse_phase_next == dnsarp_pkg::PH_FOUND) begin
      result.status  = dnsarp_pkg::ST_FOUND;
      result.address = address_accum_next;
    end else if (verdict_next != dnsarp_pkg::ST_NONE) begin
      result.status = verdict_next;
    end else begin
      result.status = dnsarp_pkg::ST_NO_A_RECORD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_id <= 16'd0;
    end else if (cfg_wr_en) begin
      expected_id <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || emit) begin
      byte_position  <= '0;
      parse_phase    <= dnsarp_pkg::PH_HEADER;
      skip_remaining <= 16'd0;
      answers_left   <= 16'd0;
      header_word    <= 16'd0;
      record_type    <= 16'd0;
      record_length  <= 16'd0;
      address_accum  <= 32'd0;
      verdict        <= dnsarp_pkg::ST_NONE;
    end else begin
      byte_position  <= byte_position_next;
      parse_phase    <= parse_phase_next;
      skip_remaining <= skip_remaining_next;
      answers_left   <= answers_left_next;
      header_word    <= header_word_next;
      record_type    <= record_type_next;
      record_length  <= record_length_next;
      address_accum  <= address_accum_next;
      verdict        <= verdict_next;
    end
  end

  // two-entry result buffer: out register plus skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_take) begin
        if (skid_valid) begin
          out_word   <= skid_word;
          skid_valid <= 1'b0;
        end else if (emit) begin
          out_word <= result;
        end else begin
          out_valid <= 1'b0;
        end
      end else if (emit) begin
        if (out_valid) begin
          skid_word  <= result;
          skid_valid <= 1'b1;
        end else begin
          out_word  <= result;
          out_valid <= 1'b1;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while output register empty");

  a_addr_only_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.status != dnsarp_pkg::ST_FOUND |-> out_word.address == 32'd0)
    else $error("address nonzero on a failed lookup");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    emit |=> byte_position == '0 && parse_phase == dnsarp_pkg::PH_HEADER)
    else $error("parser not cleared after last word");

  a_no_result_midpacket: assert property (@(posedge clk) disable iff (rst)
    !emit && !out_take |=> out_valid == $past(out_valid) && skid_valid == $past(skid_valid))
    else $error("result buffer changed without a last word or a drain");

  a_pos_bounded: assert property (@(posedge clk) disable iff (rst)
    byte_position <= PosMax)
    else $error("byte position beyond packet limit");
`endif

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int MaxPacket  = 512;
  localparam int HoldCycles = 300;
  localparam int CycleLimit = 1000000;
  localparam int MaxReports = 100;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [15:0]           cfg_wr_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  dnsarp_pkg::in_word_t  in_word = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  dnsarp_pkg::out_word_t out_word;

  dns_a_record_response_parser_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_word    (out_word)
  );

  always #5 clk = ~clk;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int errors = 0;
  int cycle_count = 0;

  dnsarp_pkg::out_word_t pending_results[$];
  dnsarp_pkg::out_word_t want_word;
  logic [7:0]            frame[$];

  // predicted parser state
  logic [15:0]        p_id;
  dnsarp_pkg::phase_t p_phase;
  logic [9:0]         p_pos;
  logic [15:0]        p_skip;
  logic [15:0]        p_answers;
  logic [15:0]        p_hdr;
  logic [15:0]        p_rtype;
  logic [15:0]        p_rlen;
  logic [31:0]        p_addr;
  logic [2:0]         p_fail;

  task automatic track_clear();
    p_phase   = dnsarp_pkg::PH_HEADER;
    p_pos     = '0;
    p_skip    = '0;
    p_answers = '0;
    p_hdr     = '0;
    p_rtype   = '0;
    p_rlen    = '0;
    p_addr    = '0;
    p_fail    = dnsarp_pkg::ST_NONE;
  endtask

  task automatic track_reject(input logic [2:0] code);
    p_fail  = code;
    p_phase = dnsarp_pkg::PH_DONE;
  endtask

  task automatic track_next_answer();
    if (p_answers == 16'd0) track_reject(dnsarp_pkg::ST_NO_A_RECORD);
    else p_phase = dnsarp_pkg::PH_ANAME;
  endtask

  task automatic track_name_end(input bit question);
    if (question) begin
      p_skip  = dnsarp_pkg::TailLen;
      p_phase = dnsarp_pkg::PH_QTAIL;
    end else begin
      p_skip  = dnsarp_pkg::FixedLen;
      p_rtype = '0;
      p_rlen  = '0;
      p_phase = dnsarp_pkg::PH_AFIXED;
    end
  endtask

  task automatic track_name_byte(input logic [7:0] b, input bit question);
    if (b == 8'd0) begin
      track_name_end(question);
    end else if ((b & dnsarp_pkg::PtrMark) == dnsarp_pkg::PtrMark) begin
      p_phase = question ? dnsarp_pkg::PH_QPTR : dnsarp_pkg::PH_APTR;
    end else begin
      p_skip  = {8'd0, b};
      p_phase = question ? dnsarp_pkg::PH_QLABEL : dnsarp_pkg::PH_ALABEL;
    end
  endtask

  task automatic track_finish_record();
    p_answers = p_answers - 16'd1;
    track_next_answer();
  endtask

  task automatic track_parse(input logic [7:0] b, input logic [9:0] pos);
    logic [3:0] idx;
    case (p_phase) inside
      dnsarp_pkg::PH_HEADER: begin
        p_hdr = {p_hdr[7:0], b};
        if (pos == 10'd1 && p_hdr != p_id) begin
          track_reject(dnsarp_pkg::ST_ID_MISMATCH);
        end else if (pos == 10'd3) begin
          if (!p_hdr[15]) track_reject(dnsarp_pkg::ST_NOT_RESPONSE);
          else if (p_hdr[3:0] != 4'd0) track_reject(dnsarp_pkg::ST_SERVER_ERROR);
        end else if (pos == 10'd7) begin
          p_answers = p_hdr;
          if (p_hdr == 16'd0) track_reject(dnsarp_pkg::ST_NO_ANSWERS);
        end else if (pos == 10'(dnsarp_pkg::HeaderBytes - 1)) begin
          p_phase = dnsarp_pkg::PH_QNAME;
        end
      end
      dnsarp_pkg::PH_QNAME: track_name_byte(b, 1'b1);
      dnsarp_pkg::PH_ANAME: track_name_byte(b, 1'b0);
      dnsarp_pkg::PH_QLABEL, dnsarp_pkg::PH_ALABEL: begin
        p_skip = p_skip - 16'd1;
        if (p_skip == 16'd0)
          p_phase = (p_phase == dnsarp_pkg::PH_QLABEL) ? dnsarp_pkg::PH_QNAME
                                                       : dnsarp_pkg::PH_ANAME;
      end
      dnsarp_pkg::PH_QPTR: track_name_end(1'b1);
      dnsarp_pkg::PH_APTR: track_name_end(1'b0);
      dnsarp_pkg::PH_QTAIL: begin
        p_skip = p_skip - 16'd1;
        if (p_skip == 16'd0) track_next_answer();
      end
      dnsarp_pkg::PH_AFIXED: begin
        idx = 4'(dnsarp_pkg::FixedLen - p_skip);
        if (idx < 4'd2) p_rtype = {p_rtype[7:0], b};
        else if (idx >= 4'd8) p_rlen = {p_rlen[7:0], b};
        p_skip = p_skip - 16'd1;
        if (p_skip == 16'd0) begin
          if (p_rtype == dnsarp_pkg::TypeA && p_rlen == dnsarp_pkg::ALength) begin
            p_skip  = dnsarp_pkg::ALength;
            p_addr  = '0;
            p_phase = dnsarp_pkg::PH_ADATA;
          end else if (p_rlen == 16'd0) begin
            track_finish_record();
          end else begin
            p_skip  = p_rlen;
            p_phase = dnsarp_pkg::PH_RSKIP;
          end
        end
      end
      dnsarp_pkg::PH_ADATA: begin
        p_addr = {p_addr[23:0], b};
        p_skip = p_skip - 16'd1;
        if (p_skip == 16'd0) p_phase = dnsarp_pkg::PH_FOUND;
      end
      dnsarp_pkg::PH_RSKIP: begin
        p_skip = p_skip - 16'd1;
        if (p_skip == 16'd0) track_finish_record();
      end
      default: ;
    endcase
  endtask

  task automatic track_word(input dnsarp_pkg::in_word_t w);
    dnsarp_pkg::out_word_t res;
    if (p_pos < 10'(MaxPacket)) begin
      track_parse(w.data_byte, p_pos);
      p_pos = p_pos + 10'd1;
    end
    if (w.last) begin
      res.address = '0;
      if (p_pos < 10'(dnsarp_pkg::HeaderBytes)) begin
        res.status = dnsarp_pkg::ST_TOO_SHORT;
      end else if (p_phase == dnsarp_pkg::PH_FOUND) begin
        res.status  = dnsarp_pkg::ST_FOUND;
        res.address = p_addr;
      end else if (p_fail != dnsarp_pkg::ST_NONE) begin
        res.status = p_fail;
      end else begin
        res.status = dnsarp_pkg::ST_NO_A_RECORD;
      end
      pending_results.push_back(res);
      track_clear();
    end
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HoldCycles;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t: unexpected word, expected none, got status=%0d address=%h",
                   $time, out_word.status, out_word.address);
      end else begin
        want_word = pending_results.pop_front();
        if (out_word.status !== want_word.status) begin
          errors++;
          if (errors <= MaxReports)
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want_word.status, out_word.status);
        end
        if (out_word.address !== want_word.address) begin
          errors++;
          if (errors <= MaxReports)
            $display("%0t: address mismatch, expected %h, got %h",
                     $time, want_word.address, out_word.address);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_word(input dnsarp_pkg::in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track_word(w);
  endtask

  task automatic send_frame();
    dnsarp_pkg::in_word_t w;
    foreach (frame[i]) begin
      w.data_byte = frame[i];
      w.last      = (i == frame.size() - 1);
      send_word(w);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_expected_id(input logic [15:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    p_id = v;
  endtask

  task automatic put8(input logic [7:0] v);
    frame.push_back(v);
  endtask

  task automatic put16(input logic [15:0] v);
    put8(v[15:8]);
    put8(v[7:0]);
  endtask

  task automatic put_header(input logic [15:0] id, input logic [15:0] flags,
                            input logic [15:0] an);
    frame = {};
    put16(id);
    put16(flags);
    put16(16'($urandom));
    put16(an);
    put16(16'($urandom));
    put16(16'($urandom));
  endtask

  task automatic put_name(input int labels, input bit ptr);
    int len;
    repeat (labels) begin
      len = $urandom_range(5, 1);
      put8(8'(len));
      repeat (len) put8(8'($urandom));
    end
    if (ptr) begin
      put8(dnsarp_pkg::PtrMark | 8'($urandom_range(63, 0)));
      put8(8'($urandom));
    end else begin
      put8(8'd0);
    end
  endtask

  task automatic put_question(input int labels, input bit ptr);
    put_name(labels, ptr);
    put16(16'($urandom));
    put16(16'($urandom));
  endtask

  task automatic put_record_body(input logic [15:0] rtype, input logic [15:0] rdlen,
                                 input logic [31:0] a);
    put16(rtype);
    put16(16'($urandom));
    put16(16'($urandom));
    put16(16'($urandom));
    put16(rdlen);
    if (rtype == dnsarp_pkg::TypeA && rdlen == dnsarp_pkg::ALength) begin
      put8(a[31:24]);
      put8(a[23:16]);
      put8(a[15:8]);
      put8(a[7:0]);
    end else begin
      repeat (int'(rdlen)) put8(8'($urandom));
    end
  endtask

  task automatic put_record(input int labels, input bit ptr, input logic [15:0] rtype,
                            input logic [15:0] rdlen, input logic [31:0] a);
    put_name(labels, ptr);
    put_record_body(rtype, rdlen, a);
  endtask

  task automatic cut_frame(input int keep);
    while (frame.size() > keep) void'(frame.pop_back());
  endtask

  task automatic pad_frame(input int total);
    while (frame.size() < total) put8(8'($urandom));
  endtask

  task automatic make_good_frame(input logic [31:0] a);
    put_header(p_id, 16'h8180, 16'd1);
    put_question(2, 1'b0);
    put_record(0, 1'b1, dnsarp_pkg::TypeA, dnsarp_pkg::ALength, a);
  endtask

  task automatic make_random_frame();
    int kind;
    int an;
    int len;
    logic [15:0] id;
    logic [15:0] flags;
    logic [15:0] rtype;
    kind = $urandom_range(99);
    frame = {};
    if (kind < 8) begin
      repeat ($urandom_range(24, 1)) put8(8'($urandom));
    end else begin
      id    = (kind < 14) ? 16'($urandom) : p_id;
      flags = (kind >= 14 && kind < 20) ? 16'($urandom)
                                        : (16'h8000 | (16'($urandom) & 16'h7FF0));
      an    = (kind >= 20 && kind < 24) ? 0 : $urandom_range(3, 1);
      put_header(id, flags, 16'(an));
      put_question($urandom_range(3, 0), $urandom_range(3, 0) == 0);
      repeat (an) begin
        if ($urandom_range(99) < 45) begin
          put_record($urandom_range(2, 0), $urandom_range(1, 0) == 1, dnsarp_pkg::TypeA,
                     dnsarp_pkg::ALength, $urandom);
        end else begin
          rtype = ($urandom_range(1, 0) == 1) ? dnsarp_pkg::TypeA
                                              : 16'($urandom_range(40, 2));
          len   = $urandom_range(6, 0);
          if (rtype == dnsarp_pkg::TypeA && len == 4) len = 5;
          put_record($urandom_range(2, 0), $urandom_range(1, 0) == 1, rtype, 16'(len), '0);
        end
      end
      if ($urandom_range(99) < 15) cut_frame($urandom_range(frame.size() - 1, 1));
      else if ($urandom_range(99) < 15) repeat ($urandom_range(6, 1)) put8(8'($urandom));
    end
    if ($urandom_range(99) < 2) pad_frame($urandom_range(560, 513));
  endtask

  task automatic test_register_reset();
    make_good_frame(32'h0A000001);
    send_frame();
  endtask

  task automatic test_config_extremes();
    set_expected_id(16'hFFFF);
    make_good_frame(32'hFFFFFFFF);
    send_frame();
    put_header(16'h0000, 16'h8180, 16'd1);
    put_question(1, 1'b0);
    send_frame();
    set_expected_id(16'h5A3C);
    make_good_frame(32'h00000000);
    send_frame();
  endtask

  task automatic test_short_packets();
    frame = {};
    put8(8'($urandom));
    send_frame();
    put_header(16'h0000, 16'h0000, 16'd0);
    cut_frame(2);
    send_frame();
    put_header(p_id, 16'h8180, 16'd1);
    cut_frame(dnsarp_pkg::HeaderBytes - 1);
    send_frame();
    put_header(p_id, 16'h8180, 16'd1);
    send_frame();
  endtask

  task automatic test_header_checks();
    put_header(~p_id, 16'h8180, 16'd1);
    put_question(1, 1'b0);
    send_frame();
    put_header(p_id, 16'h0180, 16'd1);
    put_question(1, 1'b0);
    send_frame();
    put_header(p_id, 16'h8183, 16'd1);
    put_question(1, 1'b0);
    send_frame();
    put_header(p_id, 16'hFFFF, 16'd1);
    send_frame();
    put_header(p_id, 16'h8180, 16'd0);
    put_question(1, 1'b0);
    send_frame();
    // several failures: earliest check wins
    put_header(~p_id, 16'h000F, 16'd0);
    send_frame();
    put_header(p_id, 16'h000F, 16'd0);
    send_frame();
  endtask

  task automatic test_name_forms();
    put_header(p_id, 16'h8180, 16'd1);
    put_question(0, 1'b1);
    put_record(0, 1'b1, dnsarp_pkg::TypeA, dnsarp_pkg::ALength, 32'hC0A80001);
    send_frame();
    // label lengths in the 0x40..0xBF range are plain labels
    put_header(p_id, 16'h8180, 16'd1);
    put8(8'h41);
    repeat (65) put8(8'($urandom));
    put8(8'd0);
    put16(16'd1);
    put16(16'd1);
    put8(8'hBF);
    repeat (191) put8(8'($urandom));
    put8(8'hC3);
    put8(8'h21);
    put_record_body(dnsarp_pkg::TypeA, dnsarp_pkg::ALength, 32'h7F000001);
    send_frame();
    put_header(p_id, 16'h8180, 16'd1);
    put_question(0, 1'b0);
    put_record(0, 1'b0, dnsarp_pkg::TypeA, dnsarp_pkg::ALength, 32'h01020304);
    send_frame();
  endtask

  task automatic test_record_walk();
    put_header(p_id, 16'h8180, 16'd3);
    put_question(1, 1'b1);
    put_record(1, 1'b1, 16'd5, 16'd3, '0);
    put_record(0, 1'b1, dnsarp_pkg::TypeA, 16'd6, '0);
    put_record(1, 1'b0, dnsarp_pkg::TypeA, dnsarp_pkg::ALength, 32'h08080404);
    send_frame();
    // answers run out, later A record is ignored
    put_header(p_id, 16'h8180, 16'd2);
    put_question(1, 1'b0);
    put_record(0, 1'b1, dnsarp_pkg::TypeA, 16'd0, '0);
    put_record(0, 1'b1, 16'd16, 16'd0, '0);
    put_record(0, 1'b1, dnsarp_pkg::TypeA, dnsarp_pkg::ALength, 32'h11223344);
    send_frame();
  endtask

  task automatic test_truncation();
    make_good_frame(32'hDEADBEEF);
    cut_frame(dnsarp_pkg::HeaderBytes + 2);
    send_frame();
    make_good_frame(32'hDEADBEEF);
    cut_frame(frame.size() - 8);
    send_frame();
    make_good_frame(32'hDEADBEEF);
    cut_frame(frame.size() - 2);
    send_frame();
  endtask

  task automatic test_oversize();
    make_good_frame(32'hA5A55A5A);
    pad_frame(530);
    send_frame();
    put_header(p_id, 16'h8180, 16'd1);
    repeat (9) begin
      put8(8'h3F);
      repeat (63) put8(8'($urandom));
    end
    put8(8'd0);
    put16(16'd1);
    put16(16'd1);
    put_record(0, 1'b1, dnsarp_pkg::TypeA, dnsarp_pkg::ALength, 32'h0B0B0B0B);
    send_frame();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    drain();
    hold_req = hold_req + 1;
    repeat (6) begin
      frame = {};
      put8(8'($urandom));
      send_frame();
    end
    repeat (6) begin
      make_random_frame();
      send_frame();
    end
    drain();
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall,
                                     input logic [15:0] id);
    int frames;
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    set_expected_id(id);
    frames = 0;
    while (frames < 4) begin
      if (frames == 2) set_expected_id(16'($urandom));
      make_random_frame();
      send_frame();
      frames++;
    end
  endtask

  initial begin
    p_id = '0;
    track_clear();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    test_register_reset();
    test_config_extremes();
    test_short_packets();
    test_header_checks();
    test_name_forms();
    test_record_walk();
    test_truncation();
    test_oversize();
    test_backpressure();
    test_random_traffic(0, 0, 16'h0000);
    test_random_traffic(76, 0, 16'hFFFF);
    test_random_traffic(0, 76, 16'($urandom));
    test_random_traffic(15, 15, 16'($urandom));

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
